// File: src/bitcrusher_with_high_shelf_macros.svh
// Assertion helpers shared by the RTL of the bitcrusher block.
// Build with NO_ASSERTIONS defined to drop every check.
`ifndef BITCRUSHER_WITH_HIGH_SHELF_MACROS_SVH
`define BITCRUSHER_WITH_HIGH_SHELF_MACROS_SVH

`ifndef NO_ASSERTIONS

// The condition never holds outside reset.
`define BCS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define BCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define BCS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`else

`define BCS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`define BCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`define BCS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: src/bcs_pkg.sv
`default_nettype none

package bcs_pkg;

    localparam int DEFAULT_SAMPLE_WIDTH = 24;
    localparam int DEFAULT_PHASE_WIDTH  = 16;

    localparam int QBITS_WIDTH     = 5;
    localparam int COEF_WIDTH      = 16;
    localparam int GAIN_WIDTH      = 17;
    localparam int COEF_FRAC       = 15;
    localparam int GAIN_FRAC       = 13;
    localparam int CFG_INDEX_WIDTH = 2;

    // Serial multiplier: one coefficient bit per cycle.
    localparam int MULT_WIDTH = 17;
    // Extra bits above the sample width for the allpass path operands.
    localparam int HEADROOM = 4;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_QUANT_BITS     = 2'd0,
        REG_HOLD_INCREMENT = 2'd1,
        REG_SHELF_COEF     = 2'd2,
        REG_SHELF_GAIN     = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_CS,
        ST_MUL_CV,
        ST_DIFF,
        ST_MUL_HD,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// File: src/bcs_serial_mul.sv
`default_nettype none

`include "bitcrusher_with_high_shelf_macros.svh"

// Signed serial-parallel multiplier. The multiplier operand is shifted out
// one bit per cycle, least significant first; the top bit carries negative
// weight. The partial sum shifts right, so the adder is only two bits wider
// than the multiplicand.
module bcs_serial_mul #(
    parameter int MCAND_WIDTH = bcs_pkg::DEFAULT_SAMPLE_WIDTH + bcs_pkg::HEADROOM
) (
    input  wire logic                                            clk,
    input  wire logic                                            rst_n,
    input  wire logic                                            start,
    input  wire logic signed [MCAND_WIDTH-1:0]                   mcand,
    input  wire logic        [bcs_pkg::MULT_WIDTH-1:0]           mult,
    output logic                                                 busy,
    output logic                                                 done,
    output logic signed [MCAND_WIDTH+bcs_pkg::MULT_WIDTH:0]      product
);

    localparam int MW = MCAND_WIDTH;
    localparam int MB = bcs_pkg::MULT_WIDTH;
    localparam int CW = $clog2(MB);
    localparam int SW2 = MW + 2;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [MB-1:0]        mult_reg, mult_next;
    logic signed [MW-1:0] mcand_reg, mcand_next;
    logic signed [MW:0]   hi_reg, hi_next;
    logic [MB-1:0]        lo_reg, lo_next;

    logic signed [SW2-1:0] addend;
    logic signed [SW2-1:0] sum;
    logic                  last;

    assign last = (cnt_reg == '0);

    always_comb
    begin
        addend = '0;
        if (mult_reg[0])
        begin
            if (last)
            begin
                addend = -SW2'(mcand_reg);
            end
            else
            begin
                addend = SW2'(mcand_reg);
            end
        end
        sum = SW2'(hi_reg) + addend;
    end

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        mult_next  = mult_reg;
        mcand_next = mcand_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = CW'(MB - 1);
            mult_next  = mult;
            mcand_next = mcand;
            hi_next    = '0;
            lo_next    = '0;
        end
        else if (busy_reg)
        begin
            hi_next   = sum[SW2-1:1];
            lo_next   = {sum[0], lo_reg[MB-1:1]};
            mult_next = {1'b0, mult_reg[MB-1:1]};
            cnt_next  = cnt_reg - CW'(1);
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mult_reg  <= mult_next;
        mcand_reg <= mcand_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = $signed({hi_reg, lo_reg});

    `BCS_ASSERT_NEVER(a_no_restart, clk, rst_n, start && busy_reg, "multiply restarted while busy")
    `BCS_ASSERT_NEXT(a_start_busy, clk, rst_n, start, busy_reg && !done_reg, "start did not begin a multiply")
    `BCS_ASSERT_NEVER(a_done_idle, clk, rst_n, done_reg && busy_reg, "done raised while still busy")

endmodule

`default_nettype wire

// File: src/bcs_crush.sv
`default_nettype none

// Phase accumulator and sample-and-hold with rounding to a chosen number
// of fractional bits.
module bcs_crush #(
    parameter int SAMPLE_WIDTH = bcs_pkg::DEFAULT_SAMPLE_WIDTH,
    parameter int PHASE_WIDTH  = bcs_pkg::DEFAULT_PHASE_WIDTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                load,
    input  wire logic signed [SAMPLE_WIDTH-1:0]      sample_in,
    input  wire logic [bcs_pkg::QBITS_WIDTH-1:0]     quant_bits,
    input  wire logic [PHASE_WIDTH:0]                hold_increment,
    output logic signed [SAMPLE_WIDTH-1:0]           held
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int XW = SW + 1;
    localparam int QW = bcs_pkg::QBITS_WIDTH;
    localparam logic [QW-1:0] QFULL = QW'(SW - 1);

    logic [PHASE_WIDTH-1:0]      phase_reg, phase_next;
    logic signed [SW-1:0]        held_reg, held_next;

    logic [PHASE_WIDTH+1:0]      phase_sum;
    logic                        carry;
    logic [QW-1:0]               drop;
    logic [XW-1:0]               half;
    logic [XW-1:0]               keep_mask;
    logic [XW-1:0]               rounded;
    logic signed [SW-1:0]        quantized;

    always_comb
    begin
        phase_sum = {2'b00, phase_reg} + {1'b0, hold_increment};
        carry     = |phase_sum[PHASE_WIDTH+1:PHASE_WIDTH];

        // Add half an LSB of the kept precision, then clear the dropped bits.
        drop      = QFULL - quant_bits;
        half      = XW'(1) << (drop - QW'(1));
        keep_mask = ~((XW'(1) << drop) - XW'(1));
        rounded   = ({sample_in[SW-1], sample_in} + half) & keep_mask;

        if (quant_bits >= QFULL)
        begin
            quantized = sample_in;
        end
        else if (!rounded[SW] && rounded[SW-1])
        begin
            // Rounded past the positive limit.
            quantized = {1'b0, {(SW-1){1'b1}}};
        end
        else
        begin
            quantized = rounded[SW-1:0];
        end

        phase_next = phase_reg;
        held_next  = held_reg;
        if (load)
        begin
            phase_next = phase_sum[PHASE_WIDTH-1:0];
            if (carry)
            begin
                held_next = quantized;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            held_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

    assign held = held_reg;

endmodule

`default_nettype wire

// File: src/bitcrusher_with_high_shelf.sv
// Bitcrusher with sample-and-hold and a first-order high shelf. Each accepted
// sample advances a phase accumulator by hold_increment; when the phase wraps,
// the held value is reloaded with the input rounded to quant_bits fractional
// bits (saturating at the positive limit). The held value then runs through a
// first-order allpass-based shelf, y = x + h0 * (x - allpass(x)), whose
// allpass state carries over from sample to sample. The three dependent
// products go through one shared serial multiplier that retires one
// coefficient bit per cycle. After the second multiply the sequencer forms
// x - a and starts the third, and after the third it loads the result; only
// then does it return to idle and take the next input, so a new sample is
// not taken before the last one is through. The result sits in an output
// register, so the next input can be taken while the previous result still
// waits for its output transfer; the load of a result only waits while the
// previous result has not yet transferred. Configuration registers are
// written through a simple write port and must only be changed while the
// block is idle.
`default_nettype none

`include "bitcrusher_with_high_shelf_macros.svh"

module bitcrusher_with_high_shelf #(
    parameter int SAMPLE_WIDTH = bcs_pkg::DEFAULT_SAMPLE_WIDTH,
    parameter int PHASE_WIDTH  = bcs_pkg::DEFAULT_PHASE_WIDTH,
    localparam int CFG_WIDTH   = (PHASE_WIDTH + 1 > bcs_pkg::GAIN_WIDTH) ?
                                 PHASE_WIDTH + 1 : bcs_pkg::GAIN_WIDTH
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,

    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]         sample_in,

    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]              sample_out,

    input  wire logic                                   cfg_write,
    input  wire logic [bcs_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  wire logic [CFG_WIDTH-1:0]                   cfg_data
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int QW   = bcs_pkg::QBITS_WIDTH;
    localparam int MB   = bcs_pkg::MULT_WIDTH;
    // Allpass state, multiplicand, intermediate widths.
    localparam int STW  = SW + 2;
    localparam int MW   = SW + bcs_pkg::HEADROOM;
    localparam int PW   = MW + MB + 1;
    localparam int RW15 = PW - bcs_pkg::COEF_FRAC;
    localparam int RW13 = PW - bcs_pkg::GAIN_FRAC;
    localparam int VW   = SW + 4;

    // Configuration registers.
    logic [QW-1:0]                          quant_bits_reg;
    logic [PHASE_WIDTH:0]                   hold_increment_reg;
    logic signed [bcs_pkg::COEF_WIDTH-1:0]  shelf_coef_reg;
    logic signed [bcs_pkg::GAIN_WIDTH-1:0]  shelf_gain_reg;

    // Sequencer and datapath registers.
    bcs_pkg::state_t        state_reg, state_next;
    logic signed [STW-1:0]  s_reg, s_next;
    logic signed [STW-1:0]  v_reg, v_next;
    logic signed [MW-1:0]   a_reg, a_next;
    logic                   out_valid_reg, out_valid_next;
    logic signed [SW-1:0]   sample_out_reg, sample_out_next;

    logic                   in_xfer;
    logic signed [SW-1:0]   x;

    logic                   mul_start;
    logic signed [MW-1:0]   mul_mcand;
    logic [MB-1:0]          mul_mult;
    logic                   mul_busy;
    logic                   mul_done;
    logic signed [PW-1:0]   prod;

    logic signed [RW15-1:0] rnd15;
    logic signed [RW13-1:0] rnd13;
    logic signed [VW-1:0]   v_wide;
    logic signed [STW-1:0]  v_sat;
    logic signed [MW-1:0]   diff;
    logic signed [RW13-1:0] y_wide;
    logic signed [SW-1:0]   y_sat;

    // Configuration write port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quant_bits_reg     <= QW'(SW - 1);
            hold_increment_reg <= {1'b1, {PHASE_WIDTH{1'b0}}};
            shelf_coef_reg     <= '0;
            shelf_gain_reg     <= '0;
        end
        else if (cfg_write)
        begin
            unique case (bcs_pkg::cfg_reg_t'(cfg_index))
                bcs_pkg::REG_QUANT_BITS:
                    quant_bits_reg <= cfg_data[QW-1:0];
                bcs_pkg::REG_HOLD_INCREMENT:
                    hold_increment_reg <= cfg_data[PHASE_WIDTH:0];
                bcs_pkg::REG_SHELF_COEF:
                    shelf_coef_reg <= cfg_data[bcs_pkg::COEF_WIDTH-1:0];
                bcs_pkg::REG_SHELF_GAIN:
                    shelf_gain_reg <= cfg_data[bcs_pkg::GAIN_WIDTH-1:0];
                default:
                    ;
            endcase
        end
    end

    assign in_ready = (state_reg == bcs_pkg::ST_IDLE);
    assign in_xfer  = in_valid && in_ready;

    // The held sample is updated at the input transfer and is the shelf input x
    // for the rest of the item.
    bcs_crush #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .PHASE_WIDTH  (PHASE_WIDTH)
    ) u_crush (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (in_xfer),
        .sample_in      (sample_in),
        .quant_bits     (quant_bits_reg),
        .hold_increment (hold_increment_reg),
        .held           (x)
    );

    bcs_serial_mul #(
        .MCAND_WIDTH (MW)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mul_mcand),
        .mult    (mul_mult),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (prod)
    );

    // Round half up: shift away the fraction and add back its top bit.
    always_comb
    begin
        rnd15 = $signed(prod[PW-1:bcs_pkg::COEF_FRAC])
              + $signed({{(RW15-1){1'b0}}, prod[bcs_pkg::COEF_FRAC-1]});
        rnd13 = $signed(prod[PW-1:bcs_pkg::GAIN_FRAC])
              + $signed({{(RW13-1){1'b0}}, prod[bcs_pkg::GAIN_FRAC-1]});
    end

    // v = sat(x - c*s), saturated to the allpass state width.
    always_comb
    begin
        v_wide = VW'(x) - VW'(rnd15);
        if ((&v_wide[VW-1:STW-1]) || !(|v_wide[VW-1:STW-1]))
        begin
            v_sat = v_wide[STW-1:0];
        end
        else
        begin
            v_sat = {v_wide[VW-1], {(STW-1){~v_wide[VW-1]}}};
        end
    end

    // y = sat(x + h0*d), saturated to the sample width.
    always_comb
    begin
        diff   = MW'(x) - a_reg;
        y_wide = RW13'(x) + rnd13;
        if ((&y_wide[RW13-1:SW-1]) || !(|y_wide[RW13-1:SW-1]))
        begin
            y_sat = y_wide[SW-1:0];
        end
        else
        begin
            y_sat = {y_wide[RW13-1], {(SW-1){~y_wide[RW13-1]}}};
        end
    end

    // Sequencer: c*s, then c*v, then h0*(x - a), then hand the result over.
    always_comb
    begin
        state_next      = state_reg;
        s_next          = s_reg;
        v_next          = v_reg;
        a_next          = a_reg;
        out_valid_next  = out_valid_reg;
        sample_out_next = sample_out_reg;
        mul_start       = 1'b0;
        mul_mcand       = MW'(s_reg);
        mul_mult        = MB'(shelf_coef_reg);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            bcs_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    mul_start  = 1'b1;
                    state_next = bcs_pkg::ST_MUL_CS;
                end
            end
            bcs_pkg::ST_MUL_CS:
            begin
                if (mul_done)
                begin
                    v_next     = v_sat;
                    mul_start  = 1'b1;
                    mul_mcand  = MW'(v_sat);
                    state_next = bcs_pkg::ST_MUL_CV;
                end
            end
            bcs_pkg::ST_MUL_CV:
            begin
                if (mul_done)
                begin
                    a_next     = MW'(rnd15) + MW'(s_reg);
                    state_next = bcs_pkg::ST_DIFF;
                end
            end
            bcs_pkg::ST_DIFF:
            begin
                s_next     = v_reg;
                mul_start  = 1'b1;
                mul_mcand  = diff;
                mul_mult   = MB'(shelf_gain_reg);
                state_next = bcs_pkg::ST_MUL_HD;
            end
            bcs_pkg::ST_MUL_HD:
            begin
                if (mul_done)
                begin
                    state_next = bcs_pkg::ST_OUT;
                end
            end
            bcs_pkg::ST_OUT:
            begin
                // The product stays put until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    sample_out_next = y_sat;
                    state_next      = bcs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bcs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bcs_pkg::ST_IDLE;
            s_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            s_reg         <= s_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg          <= v_next;
        a_reg          <= a_next;
        sample_out_reg <= sample_out_next;
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

    `BCS_ASSERT_NEVER(a_idle_mul_quiet, clk, rst_n, in_ready && mul_busy,
        "multiplier busy while idle")
    `BCS_ASSERT_IMPLY(a_done_in_mul_state, clk, rst_n, mul_done,
        state_reg == bcs_pkg::ST_MUL_CS || state_reg == bcs_pkg::ST_MUL_CV ||
        state_reg == bcs_pkg::ST_MUL_HD, "product finished outside a multiply step")
    `BCS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_reg && !out_ready,
        out_valid_reg && $stable(sample_out_reg), "result changed before its transfer")

endmodule

`default_nettype wire

// File: dv/bitcrusher_with_high_shelf_test.sv
`default_nettype none

module bitcrusher_with_high_shelf_test;

    localparam int SW    = bcs_pkg::DEFAULT_SAMPLE_WIDTH;
    localparam int PW    = bcs_pkg::DEFAULT_PHASE_WIDTH;
    // The allpass state carries two guard bits above the sample width.
    localparam int STW   = SW + 2;
    localparam int CFG_W = (PW + 1 > bcs_pkg::GAIN_WIDTH) ? PW + 1 : bcs_pkg::GAIN_WIDTH;

    // Each random phase uses a fresh register setting and this many samples.
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_SAMPLES  = 125;
    // This wait covers a result that is still being computed inside the
    // block, with some margin.
    localparam int DRAIN_CYCLES   = 80;

    logic                                   clk = 1'b0;
    logic                                   rst_n = 1'b0;
    logic                                   in_valid = 1'b0;
    logic                                   in_ready;
    logic signed [SW-1:0]                   sample_in = '0;
    logic                                   out_valid;
    logic                                   out_ready = 1'b0;
    logic signed [SW-1:0]                   sample_out;
    logic                                   cfg_write = 1'b0;
    logic [bcs_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]                       cfg_data = '0;

    bitcrusher_with_high_shelf u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Samples waiting to be offered to the block, and the processed samples
    // that the block owes us, oldest first.
    logic [SW-1:0]  source_samples[$];
    logic [SW-1:0]  shelved_samples[$];

    // Percentage of cycles in which each side holds back.
    int             send_idle_pct = 16;
    int             recv_idle_pct = 50;
    int             send_gap = 0;

    int             errors = 0;
    int             inputs_sent = 0;
    int             results_checked = 0;
    int             settings_used = 1;

    // Our own copy of the register file, starting at the reset values.
    int             quant_cfg = SW - 1;
    longint         incr_cfg = longint'(1) << PW;
    longint         coef_cfg = 0;
    longint         gain_cfg = 0;

    // Our own copy of the block's state, also starting at reset.
    longint         phase_acc = 0;
    longint         held_level = 0;
    longint         allpass_mem = 0;

    // Scale down by 2^n, rounding half toward plus infinity. The arithmetic
    // shift of a signed value is a floor, which is what the rounding needs.
    function automatic longint round_down_by(longint v, int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clamp_to(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -(longint'(1) <<< (w - 1));
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // Advances the model by one accepted sample and returns the output that
    // the block must produce for it.
    function automatic logic [SW-1:0] crush_and_shelve(logic [SW-1:0] raw);
        longint phase_sum;
        longint x;
        longint v;
        longint a;
        longint y;
        longint offset;
        int     drop;
        phase_sum = phase_acc + incr_cfg;
        // Any carry out of the phase, even a double one, reloads once.
        if ((phase_sum >> PW) != 0)
        begin
            x = longint'($signed(raw));
            if (quant_cfg < SW - 1)
            begin
                // Shift into a non-negative range so that rounding is a plain
                // add and truncate; the offset is a multiple of the step.
                drop = SW - 1 - quant_cfg;
                offset = longint'(1) <<< (SW - 1);
                x = (((x + offset + (longint'(1) <<< (drop - 1))) >>> drop) <<< drop)
                    - offset;
                if (x > offset - 1)
                    x = offset - 1;
            end
            held_level = x;
        end
        phase_acc = phase_sum & ((longint'(1) << PW) - 1);

        x = held_level;
        v = clamp_to(x - round_down_by(coef_cfg * allpass_mem, bcs_pkg::COEF_FRAC), STW);
        a = round_down_by(coef_cfg * v, bcs_pkg::COEF_FRAC) + allpass_mem;
        allpass_mem = v;
        y = clamp_to(x + round_down_by(gain_cfg * (x - a), bcs_pkg::GAIN_FRAC), SW);
        return y[SW-1:0];
    endfunction

    // Only the first ten failures are described; the rest are counted.
    task automatic flag_error(string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endtask

    // Writes all four registers, one per cycle. It is only called while no
    // sample is inside the block, so the model may take the new values at once.
    task automatic apply_settings(int q, longint inc, longint c, longint g);
        quant_cfg = q;
        incr_cfg = inc;
        coef_cfg = c;
        gain_cfg = g;
        settings_used++;
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= bcs_pkg::REG_QUANT_BITS;
        cfg_data  <= CFG_W'(q);
        @(posedge clk);
        cfg_index <= bcs_pkg::REG_HOLD_INCREMENT;
        cfg_data  <= CFG_W'(inc);
        @(posedge clk);
        cfg_index <= bcs_pkg::REG_SHELF_COEF;
        cfg_data  <= CFG_W'(c);
        @(posedge clk);
        cfg_index <= bcs_pkg::REG_SHELF_GAIN;
        cfg_data  <= CFG_W'(g);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Returns once every queued sample has been taken and every result has
    // come back. The check runs on the falling edge, away from all updates.
    task automatic wait_drained();
        @(negedge clk);
        while (source_samples.size() != 0 || in_valid || shelved_samples.size() != 0)
            @(negedge clk);
    endtask

    // Input driver. A new sample is presented only when the slot is free,
    // that is when nothing is shown or the shown sample transfers at this
    // edge. Besides the per-cycle idling, a sample is sometimes followed by a
    // longer gap so that the next one arrives at any point of the block's
    // computation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            sample_in <= '0;
            send_gap  <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                shelved_samples.push_back(crush_and_shelve(sample_in));
                inputs_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (source_samples.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid  <= 1'b1;
                    sample_in <= source_samples.pop_front();
                    if ($urandom_range(99) < send_idle_pct)
                        send_gap <= $urandom_range(70, 1);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor. Every output transfer is matched against the oldest
    // outstanding expectation; out_ready is redrawn every cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (shelved_samples.size() == 0)
                begin
                    flag_error($sformatf("unexpected output transfer: sample_out %0d",
                                         sample_out));
                end
                else
                begin
                    logic [SW-1:0] want;
                    want = shelved_samples.pop_front();
                    if (sample_out !== want)
                        flag_error($sformatf(
                            "sample_out mismatch on result %0d: expected %0d, got %0d",
                            results_checked, $signed(want), sample_out));
                    results_checked++;
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int     q;
        longint inc;
        longint c;
        longint g;
        int     walk;
        logic [SW-1:0] pick;

        walk = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values pass samples straight through, so the extremes of the
        // input must come back unchanged.
        source_samples = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF,
                           24'h000001, 24'h555555, 24'hAAAAAA};
        wait_drained();

        // Coarsest rounding: everything lands on -1, 0 or the positive limit,
        // and a half rounds up, which saturates.
        apply_settings(0, 65536, 0, 0);
        source_samples = '{24'h7FFFFF, 24'h400000, 24'h3FFFFF, 24'hC00000,
                           24'hBFFFFF, 24'h800000};
        wait_drained();

        // One fractional bit: the largest sample rounds past the positive
        // limit and saturates. The largest increment carries on every sample,
        // and the coefficient and gain sit at their most negative and most
        // positive values.
        apply_settings(1, 131071, -32768, 65535);
        source_samples = '{24'h7FFFFF, 24'h800000, 24'h01E240, 24'h8B3B4F};
        wait_drained();

        // A zero increment never reloads, so the held value stays while the
        // shelf keeps running on it. A quant setting beyond the sample width
        // keeps full precision.
        apply_settings(31, 0, 32767, -65536);
        source_samples = '{24'h0003E8, 24'h0007D0, 24'h000BB8};
        wait_drained();

        apply_settings(22, 40000, 32767, -4096);
        source_samples = '{24'h123456, 24'hEDCBA9, 24'h7FFFFF, 24'h800000, 24'h000000};
        wait_drained();

        // Random phases: a new register setting each time, leaning toward the
        // extremes. The first third lets the receiver stall more than the
        // sender idles, the second third the reverse, the last third neither.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph / (RANDOM_PHASES / 3))
                0:
                begin
                    send_idle_pct = 16;
                    recv_idle_pct = 50;
                end
                1:
                begin
                    send_idle_pct = 50;
                    recv_idle_pct = 16;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            case ($urandom_range(5))
                0: q = 0;
                1: q = 1;
                2: q = SW - 1;
                3: q = 31;
                default: q = $urandom_range(31);
            endcase
            case ($urandom_range(5))
                0: inc = 65536;
                1: inc = 131071;
                2: inc = $urandom_range(200, 1);
                3: inc = $urandom_range(65535, 32768);
                default: inc = $urandom_range(131071);
            endcase
            case ($urandom_range(4))
                0: c = -32768;
                1: c = 32767;
                2: c = 0;
                default: c = $signed(16'($urandom));
            endcase
            case ($urandom_range(6))
                0: g = -65536;
                1: g = 65535;
                2: g = -4096;
                3: g = 0;
                4: g = $signed(17'($urandom_range(16383))) - 4096;
                default: g = $signed(17'($urandom));
            endcase
            apply_settings(q, inc, c, g);

            // Mostly full-range noise, with a slowly moving signal and the
            // rails mixed in so the shelf also sees audio-like material.
            for (int n = 0; n < PHASE_SAMPLES; n++)
            begin
                case ($urandom_range(9))
                    0: pick = 24'h7FFFFF;
                    1: pick = 24'h800000;
                    2, 3:
                    begin
                        walk = walk + int'($urandom_range(200000)) - 100000;
                        pick = SW'(walk);
                    end
                    default: pick = SW'($urandom);
                endcase
                source_samples.push_back(pick);
            end
            wait_drained();
        end

        // Give a stray extra result the chance to show up.
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d input transfers under %0d register settings; %0d results checked.",
                 inputs_sent, settings_used, results_checked);
        $display("Failures: %0d, results still owed: %0d.", errors, shelved_samples.size());
        if (errors == 0 && shelved_samples.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #8000000;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
